// ===== design/poi_pkg.sv =====
// Shared types, constants and tables for the planar odometry integrator.
// Used by poi_cordic, poi_mul and planar_odometry_integrator_top.
package poi_pkg;

  localparam int POS_BITS_DEF   = 40;
  localparam int ANGLE_BITS_DEF = 32;

  // Sine/cosine datapath widths.
  localparam int CS_W   = 18;  // Q1.16 result, holds +-65536
  localparam int CXY_W  = 20;  // CORDIC x/y working registers
  localparam int CZ_W   = 32;  // CORDIC residual angle
  localparam int CITERS = 16;

  localparam logic signed [CXY_W-1:0] CORDIC_X0 = CXY_W'(39797);
  localparam logic signed [CS_W-1:0]  UNIT_Q16  = CS_W'(65536);

  // Shared multiplier operand widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 27;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // round(2^24 * 8 / pi), converts Q.28 radians to a binary angle.
  localparam logic signed [MUL_B_W-1:0] HEAD_GAIN = MUL_B_W'(42722830);

  // Rounded position step in Q.16, taken from the Q.44 product.
  localparam int DELTA_W   = 24;
  localparam int DELTA_LSB = 28;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_PA,
    ST_PB,
    ST_DX,
    ST_PC,
    ST_PD,
    ST_DY,
    ST_PR,
    ST_GN,
    ST_HD,
    ST_OUT
  } poi_state_e;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic signed [CZ_W-1:0] poi_atan(input logic [3:0] idx);
    logic signed [CZ_W-1:0] v;
    unique case (idx)
      4'd0:    v = 32'sh2000_0000;
      4'd1:    v = 32'sh12E4_051E;
      4'd2:    v = 32'sh09FB_385B;
      4'd3:    v = 32'sh0511_11D4;
      4'd4:    v = 32'sh028B_0D43;
      4'd5:    v = 32'sh0145_D7E1;
      4'd6:    v = 32'sh00A2_F61E;
      4'd7:    v = 32'sh0051_7C55;
      4'd8:    v = 32'sh0028_BE53;
      4'd9:    v = 32'sh0014_5F2F;
      4'd10:   v = 32'sh000A_2F98;
      4'd11:   v = 32'sh0005_17CC;
      4'd12:   v = 32'sh0002_8BE6;
      4'd13:   v = 32'sh0001_45F3;
      4'd14:   v = 32'sh0000_A2FA;
      4'd15:   v = 32'sh0000_517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/poi_cordic.sv =====
// Iterative CORDIC sine/cosine unit, one micro-rotation per cycle.
// Depends on poi_pkg for widths and the arctangent table.
module poi_cordic import poi_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ANGLE_BITS-1:0]  angle_i,
  output logic                   done_o,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  logic                    busy_q;
  logic                    done_q;
  logic [3:0]              iter_q;
  logic [1:0]              quad_q;
  logic signed [CXY_W-1:0] x_q, x_d;
  logic signed [CXY_W-1:0] y_q, y_d;
  logic signed [CZ_W-1:0]  z_q, z_d;

  logic [31:0]             h;
  logic [31:0]             h_bias;
  logic [1:0]              quad;
  logic signed [CXY_W-1:0] xs, ys;
  logic signed [CS_W-1:0]  xc, yc;

  // Fold the angle into the nearest quadrant so the rotation stays within +-45 degrees.
  assign h      = 32'(angle_i) << (32 - ANGLE_BITS);
  assign h_bias = h + 32'h2000_0000;
  assign quad   = h_bias[31:30];

  assign xs = x_q >>> iter_q;
  assign ys = y_q >>> iter_q;

  always_comb begin
    if (z_q >= 0) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - poi_atan(iter_q);
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + poi_atan(iter_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 4'd1;
        if (iter_q == 4'(CITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= $signed(h - {quad, 30'd0});
      quad_q <= quad;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_comb begin
    if (x_q > CXY_W'(UNIT_Q16)) begin
      xc = UNIT_Q16;
    end else if (x_q < -CXY_W'(UNIT_Q16)) begin
      xc = -UNIT_Q16;
    end else begin
      xc = CS_W'(x_q);
    end
    if (y_q > CXY_W'(UNIT_Q16)) begin
      yc = UNIT_Q16;
    end else if (y_q < -CXY_W'(UNIT_Q16)) begin
      yc = -UNIT_Q16;
    end else begin
      yc = CS_W'(y_q);
    end
    unique case (quad_q)
      2'd0: begin
        cos_o = xc;
        sin_o = yc;
      end
      2'd1: begin
        cos_o = -yc;
        sin_o = xc;
      end
      2'd2: begin
        cos_o = -xc;
        sin_o = -yc;
      end
      default: begin
        cos_o = yc;
        sin_o = -xc;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== design/poi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on poi_pkg for the default operand widths.
module poi_mul import poi_pkg::*; #(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic                      clk_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== design/planar_odometry_integrator_top.sv =====
// Planar dead-reckoning odometry: sequencer, state registers and result register.
// Depends on poi_pkg, poi_cordic and poi_mul.
//
//   channel   signals                                        direction
//   in        in_valid_i, in_stall_o, vel_fwd_i, vel_side_i,  into block
//             yaw_rate_raw_i, elapsed_i
//   out       out_valid_o, out_stall_i, pos_x_o, pos_y_o,     out of block
//             heading_o, yaw_rate_used_o
//   cfg       cfg_we_i, cfg_wdata_i (rate deadband)           into block
//
// An item runs 16 CORDIC micro-rotations for the heading's sine and cosine, then
// eight steps of the one shared multiplier for both position steps and the heading
// step. The input is stalled while an item is in work.
// A finished result sits in the output register; the next item is accepted while
// it waits, and the sequencer only holds before loading the register again.
// Reset clears position and heading to zero and the deadband to 41.
module planar_odometry_integrator_top import poi_pkg::*; #(
  parameter int POS_BITS   = POS_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [14:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [15:0]         vel_fwd_i,
  input  logic signed [15:0]         vel_side_i,
  input  logic signed [15:0]         yaw_rate_raw_i,
  input  logic [15:0]                elapsed_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [POS_BITS-1:0] pos_x_o,
  output logic signed [POS_BITS-1:0] pos_y_o,
  output logic [ANGLE_BITS-1:0]      heading_o,
  output logic signed [15:0]         yaw_rate_used_o
);

  localparam int HEAD_SH = 56 - ANGLE_BITS;

  poi_state_e state_q, state_d;

  logic [14:0]                db_q;
  logic signed [POS_BITS-1:0] world_x_q, world_x_d;
  logic signed [POS_BITS-1:0] world_y_q, world_y_d;
  logic [ANGLE_BITS-1:0]      yaw_q, yaw_d;
  logic signed [15:0]         vf_q, vs_q, r_q;
  logic [15:0]                dt_q;
  logic signed [MUL_A_W-1:0]  acc_q;
  logic                       neg_q;
  logic                       out_valid_q;
  logic signed [POS_BITS-1:0] out_x_q, out_y_q;
  logic [ANGLE_BITS-1:0]      out_head_q;
  logic signed [15:0]         out_rate_q;

  logic                       in_acc;
  logic                       out_load;
  logic                       cordic_start;
  logic                       cordic_done;
  logic signed [CS_W-1:0]     cos_v, sin_v;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;
  logic signed [MUL_A_W-1:0]  prod_lo;
  logic signed [MUL_B_W-1:0]  dt_b;
  logic signed [16:0]         r_ext, db_ext;
  logic signed [15:0]         r_used;
  logic signed [MUL_P_W-1:0]  prod_rnd;
  logic signed [DELTA_W-1:0]  delta;
  logic signed [POS_BITS-1:0] pos_cur;
  logic signed [POS_BITS:0]   pos_sum;
  logic signed [POS_BITS-1:0] pos_new;
  logic [MUL_P_W-1:0]         mag_rnd;
  logic [ANGLE_BITS-1:0]      head_step;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  // A raw rate strictly inside the deadband is taken as zero.
  assign r_ext  = 17'(yaw_rate_raw_i);
  assign db_ext = $signed({2'b00, db_q});
  assign r_used = ((r_ext > -db_ext) && (r_ext < db_ext)) ? 16'sd0 : yaw_rate_raw_i;

  assign cordic_start = in_acc;

  poi_cordic #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (yaw_q),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  poi_mul #(
    .A_W(MUL_A_W),
    .B_W(MUL_B_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_lo = $signed(prod[MUL_A_W-1:0]);
  assign dt_b    = $signed({{(MUL_B_W-16){1'b0}}, dt_q});

  // Q.44 product rounded to Q.16 and added to the selected axis with saturation.
  assign prod_rnd = prod + MUL_P_W'(1 << (DELTA_LSB - 1));
  assign delta    = $signed(prod_rnd[DELTA_LSB +: DELTA_W]);
  assign pos_cur  = (state_q == ST_PC) ? world_x_q : world_y_q;
  assign pos_sum  = (POS_BITS+1)'(pos_cur) + (POS_BITS+1)'(delta);

  always_comb begin
    if (pos_sum[POS_BITS] != pos_sum[POS_BITS-1]) begin
      pos_new = pos_sum[POS_BITS] ? {1'b1, {(POS_BITS-1){1'b0}}}
                                  : {1'b0, {(POS_BITS-1){1'b1}}};
    end else begin
      pos_new = pos_sum[POS_BITS-1:0];
    end
  end

  // Heading step magnitude, rounded half up, then given the sign of the rate.
  assign mag_rnd   = prod + MUL_P_W'(64'd1 << (HEAD_SH - 1));
  assign head_step = neg_q ? (ANGLE_BITS'(0) - mag_rnd[HEAD_SH +: ANGLE_BITS])
                           : mag_rnd[HEAD_SH +: ANGLE_BITS];

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    world_x_d = world_x_q;
    world_y_d = world_y_q;
    yaw_d     = yaw_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          state_d = ST_PA;
        end
      end
      ST_PA: begin
        mul_a   = MUL_A_W'(vf_q);
        mul_b   = MUL_B_W'(cos_v);
        state_d = ST_PB;
      end
      ST_PB: begin
        mul_a   = MUL_A_W'(vs_q);
        mul_b   = MUL_B_W'(sin_v);
        state_d = ST_DX;
      end
      ST_DX: begin
        mul_a   = acc_q - prod_lo;
        mul_b   = dt_b;
        state_d = ST_PC;
      end
      ST_PC: begin
        world_x_d = pos_new;
        mul_a     = MUL_A_W'(vf_q);
        mul_b     = MUL_B_W'(sin_v);
        state_d   = ST_PD;
      end
      ST_PD: begin
        mul_a   = MUL_A_W'(vs_q);
        mul_b   = MUL_B_W'(cos_v);
        state_d = ST_DY;
      end
      ST_DY: begin
        mul_a   = acc_q + prod_lo;
        mul_b   = dt_b;
        state_d = ST_PR;
      end
      ST_PR: begin
        world_y_d = pos_new;
        mul_a     = MUL_A_W'(r_q);
        mul_b     = dt_b;
        state_d   = ST_GN;
      end
      ST_GN: begin
        mul_a   = (prod_lo < 0) ? -prod_lo : prod_lo;
        mul_b   = HEAD_GAIN;
        state_d = ST_HD;
      end
      ST_HD: begin
        yaw_d   = yaw_q + head_step;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      db_q        <= 15'd41;
      world_x_q   <= '0;
      world_y_q   <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      world_x_q <= world_x_d;
      world_y_q <= world_y_d;
      yaw_q     <= yaw_d;
      if (cfg_we_i) begin
        db_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vf_q <= vel_fwd_i;
      vs_q <= vel_side_i;
      r_q  <= r_used;
      dt_q <= elapsed_i;
    end
    if (state_q == ST_PB || state_q == ST_PD) begin
      acc_q <= prod_lo;
    end
    if (state_q == ST_GN) begin
      neg_q <= (prod_lo < 0);
    end
    if (out_load) begin
      out_x_q    <= world_x_q;
      out_y_q    <= world_y_q;
      out_head_q <= yaw_q;
      out_rate_q <= r_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = out_x_q;
  assign pos_y_o         = out_y_q;
  assign heading_o       = out_head_q;
  assign yaw_rate_used_o = out_rate_q;

endmodule

// ===== dv/planar_odometry_integrator_top_tb.sv =====
// Self-checking testbench for planar_odometry_integrator_top: directed and random ticks,
// checked against a fixed-point pose predictor kept inside the bench.
// Depends on poi_pkg and the planar_odometry_integrator_top RTL.
module planar_odometry_integrator_top_tb;
  import poi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W   = POS_BITS_DEF;
  localparam int ANGLE_W = ANGLE_BITS_DEF;
  localparam int LIMIT   = 500000;

  localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF >> (32 - ANGLE_W);
  localparam longint HEADING_GAIN = 64'd42722830;
  localparam int COS_SEED = 39797;
  localparam int UNIT = 65536;

  // Arctangent of 2^-i as a binary angle, entry 15 first.
  localparam logic [15:0][31:0] ATAN_TAB = {
    32'h0000_517D, 32'h0000_A2FA, 32'h0001_45F3, 32'h0002_8BE6,
    32'h0005_17CC, 32'h000A_2F98, 32'h0014_5F2F, 32'h0028_BE53,
    32'h0051_7C55, 32'h00A2_F61E, 32'h0145_D7E1, 32'h028B_0D43,
    32'h0511_11D4, 32'h09FB_385B, 32'h12E4_051E, 32'h2000_0000
  };

  typedef struct packed {
    logic signed [15:0] vel_fwd;
    logic signed [15:0] vel_side;
    logic signed [15:0] yaw_rate;
    logic [15:0]        elapsed;
  } tick_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANGLE_W-1:0]      heading;
    logic signed [15:0]      yaw_used;
  } pose_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [14:0]             cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [15:0]      vel_fwd_i = '0;
  logic signed [15:0]      vel_side_i = '0;
  logic signed [15:0]      yaw_rate_raw_i = '0;
  logic [15:0]             elapsed_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [POS_W-1:0] pos_x_o;
  logic signed [POS_W-1:0] pos_y_o;
  logic [ANGLE_W-1:0]      heading_o;
  logic signed [15:0]      yaw_rate_used_o;

  tick_t  ticks_q[$];
  pose_t  pose_q[$];
  tick_t  nxt_tick;
  tick_t  seen_tick;
  pose_t  want_pose;
  logic   in_taken = 1'b0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     mismatches = 0;
  int     results_seen = 0;
  int     cycle_count = 0;

  // Predicted block state.
  longint      est_x = 0;
  longint      est_y = 0;
  logic [31:0] est_yaw = '0;
  logic [14:0] deadband_q = 15'd41;

  planar_odometry_integrator_top #(
    .POS_BITS  (POS_W),
    .ANGLE_BITS(ANGLE_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vel_fwd_i      (vel_fwd_i),
    .vel_side_i     (vel_side_i),
    .yaw_rate_raw_i (yaw_rate_raw_i),
    .elapsed_i      (elapsed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o),
    .yaw_rate_used_o(yaw_rate_used_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint sat_step(input longint pos, input longint d);
    longint mx, mn;
    mx = (longint'(1) <<< (POS_W - 1)) - 1;
    mn = -mx - 1;
    if (d > 0 && pos > mx - d) return mx;
    if (d < 0 && pos < mn - d) return mn;
    return pos + d;
  endfunction

  // Advances the predicted pose by one tick and returns the result the block must give.
  function automatic pose_t integrate_tick(input tick_t t);
    int          cs, sn, x, y, z, xs, ys, db, r, i, sh;
    logic [31:0] h, hq, resid, step;
    logic [1:0]  quad;
    longint      dx, dy, p;
    logic [63:0] mag;
    pose_t       res;
    db = int'(deadband_q);
    r  = int'($signed(t.yaw_rate));
    if (r > -db && r < db) r = 0;

    // Sine and cosine of the heading held before the tick, reduced to the nearest quadrant.
    h     = est_yaw << (32 - ANGLE_W);
    hq    = h + 32'h2000_0000;
    quad  = hq[31:30];
    resid = h - {quad, 30'd0};
    z     = $signed(resid);
    x     = COS_SEED;
    y     = 0;
    for (i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - $signed(ATAN_TAB[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + $signed(ATAN_TAB[i]);
      end
    end
    if (x > UNIT) x = UNIT;
    if (x < -UNIT) x = -UNIT;
    if (y > UNIT) y = UNIT;
    if (y < -UNIT) y = -UNIT;
    case (quad)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase

    dx = (longint'($signed(t.vel_fwd)) * cs - longint'($signed(t.vel_side)) * sn)
         * longint'(t.elapsed);
    dy = (longint'($signed(t.vel_fwd)) * sn + longint'($signed(t.vel_side)) * cs)
         * longint'(t.elapsed);
    est_x = sat_step(est_x, (dx + (longint'(1) <<< 27)) >>> 28);
    est_y = sat_step(est_y, (dy + (longint'(1) <<< 27)) >>> 28);

    // The heading step is rounded on its magnitude, half away from zero.
    sh  = 56 - ANGLE_W;
    p   = longint'(r) * longint'(t.elapsed);
    mag = (p < 0) ? 64'(-p) : 64'(p);
    mag = mag * 64'(HEADING_GAIN);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    step = mag[31:0];
    if (p < 0) step = 32'd0 - step;
    est_yaw = (est_yaw + step) & ANG_MASK;

    res.pos_x    = POS_W'(est_x);
    res.pos_y    = POS_W'(est_y);
    res.heading  = est_yaw[ANGLE_W-1:0];
    res.yaw_used = 16'(r);
    return res;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] result %0d %s: got %0d, expected %0d", $realtime, results_seen, what,
               got, want);
  endtask

  task automatic queue_tick(input int vf, input int vs, input int r, input int dt);
    tick_t t;
    t.vel_fwd  = 16'(vf);
    t.vel_side = 16'(vs);
    t.yaw_rate = 16'(r);
    t.elapsed  = 16'(dt);
    ticks_q.push_back(t);
  endtask

  task automatic wait_quiet();
    while (ticks_q.size() != 0 || in_valid_i || pose_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [14:0] db, input int idle, input int stall,
                              input int n);
    int kind, len, left, vf, vs, r, dt, k;
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= db;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    idle_pct  = idle;
    stall_pct = stall;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(99);
      vf = $urandom;
      vs = $urandom;
      r  = $urandom;
      dt = $urandom;
      if (kind == 0) begin
        // A straight run at full speed and full tick length builds up a large position.
        len = $urandom_range(40, 12);
        vf = $urandom_range(1) ? 32767 : -32768;
        vs = $urandom_range(1) ? 32767 : -32768;
        for (k = 0; k < len; k++) queue_tick(vf, vs, 0, 65535);
        left -= len;
      end else begin
        if (kind < 20) begin
          r = int'(db) - 1 + $urandom_range(2);
          if (r > 32767) r = 32767;
          if ($urandom_range(1)) r = -r;
        end else if (kind < 30) begin
          vf = $urandom_range(1) ? 32767 : -32768;
          vs = $urandom_range(1) ? 32767 : -32768;
          r  = $urandom_range(1) ? 32767 : -32768;
          dt = $urandom_range(1) ? 65535 : 0;
        end
        queue_tick(vf, vs, r, dt);
        left--;
      end
    end
  endtask

  // Driver: presents queued ticks and drives the result stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (!in_valid_i || in_taken) begin
        if (ticks_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt_tick = ticks_q.pop_front();
          in_valid_i     <= 1'b1;
          vel_fwd_i      <= nxt_tick.vel_fwd;
          vel_side_i     <= nxt_tick.vel_side;
          yaw_rate_raw_i <= nxt_tick.yaw_rate;
          elapsed_i      <= nxt_tick.elapsed;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on every accepted tick and checks every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (cfg_we_i) deadband_q = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          note_mismatch("result with nothing expected", pos_x_o, 0);
        end else begin
          want_pose = pose_q.pop_front();
          if (pos_x_o !== want_pose.pos_x) note_mismatch("pos_x", pos_x_o, want_pose.pos_x);
          if (pos_y_o !== want_pose.pos_y) note_mismatch("pos_y", pos_y_o, want_pose.pos_y);
          if (heading_o !== want_pose.heading)
            note_mismatch("heading", heading_o, want_pose.heading);
          if (yaw_rate_used_o !== want_pose.yaw_used)
            note_mismatch("yaw_rate_used", yaw_rate_used_o, want_pose.yaw_used);
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        seen_tick.vel_fwd  = vel_fwd_i;
        seen_tick.vel_side = vel_side_i;
        seen_tick.yaw_rate = yaw_rate_raw_i;
        seen_tick.elapsed  = elapsed_i;
        pose_q.push_back(integrate_tick(seen_tick));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset deadband.
    queue_tick(0, 0, 0, 0);
    queue_tick(32767, 0, 0, 65535);
    queue_tick(-32768, 0, 0, 65535);
    queue_tick(0, 32767, 0, 65535);
    queue_tick(0, -32768, 0, 65535);
    queue_tick(32767, 32767, 40, 1);
    queue_tick(0, 0, -40, 65535);
    queue_tick(0, 0, 41, 65535);
    queue_tick(0, 0, -41, 65535);
    queue_tick(0, 0, 32767, 65535);
    queue_tick(0, 0, 32767, 65535);
    queue_tick(-32768, -32768, -32768, 65535);
    queue_tick(32767, -32768, -32768, 0);
    queue_tick(12345, -777, 6434, 32768);
    for (k = 0; k < 11; k++) queue_tick(-32768, -32768, 0, 65535);

    random_phase(15'd0, 0, 0, 250);
    random_phase(15'd32767, 79, 0, 250);
    random_phase(15'd41, 0, 79, 250);
    random_phase(15'($urandom_range(32767)), 12, 12, 250);
    random_phase(15'd1, 0, 79, 250);
    random_phase(15'($urandom_range(200)), 79, 0, 250);

    wait_quiet();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
